>>> rtl/core/pcm_bytes_to_q31_samples_unit_macros.svh
// ----------------------------------------------------------------------------
// PCM to Q31 converter assertion macros
// Concurrent assertion wrappers shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef PCM_BYTES_TO_Q31_SAMPLES_UNIT_MACROS_SVH
`define PCM_BYTES_TO_Q31_SAMPLES_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbq: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbq: next-cycle check failed");
`else
`define PBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/pbq_pkg.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter package
// Shared types, register map and format constants.
// ----------------------------------------------------------------------------
package pbq_pkg;

  // Configuration port address width: four 32-bit registers
  localparam int ADDR_W = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SAMPLE_TYPE      = 2'd0;
  localparam logic [1:0] REG_BYTES_PER_SAMPLE = 2'd1;
  localparam logic [1:0] REG_LITTLE_ENDIAN    = 2'd2;
  localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd3;

  // Sample encodings; the fourth code is unknown and decodes to zero
  localparam logic [1:0] SMP_SIGNED   = 2'd0;
  localparam logic [1:0] SMP_UNSIGNED = 2'd1;
  localparam logic [1:0] SMP_FLOAT    = 2'd2;

  localparam logic [2:0] BYTES_MIN = 3'd1;
  localparam logic [2:0] BYTES_MAX = 3'd4;

  localparam logic [31:0] Q31_POS_FULL = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_NEG_FULL = 32'h8000_0000;
  localparam logic [31:0] OFFSET_FLIP  = 32'h8000_0000;

  // Single float: exponent at which |v| * 2^31 no longer fits, and the
  // exponent at which the 24-bit mantissa lands unshifted in Q31
  localparam logic [7:0] F_EXP_SAT  = 8'd127;
  localparam logic [7:0] F_EXP_BASE = 8'd119;
  localparam logic [7:0] F_EXP_SPEC = 8'hFF;
  localparam logic [7:0] F_MAN_BITS = 8'd24;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] sample_type;
    logic [2:0] bytes_per_sample;
    logic       little_endian;
    logic [3:0] channel_count;
  } pbq_cfg_t;

  localparam pbq_cfg_t CFG_RESET = '{
    sample_type:      SMP_SIGNED,
    bytes_per_sample: 3'd2,
    little_endian:    1'b1,
    channel_count:    4'd1
  };

  // One completed sample, bytes already placed by significance
  typedef struct packed {
    logic [31:0] raw;
    logic [2:0]  nbytes;
    logic [1:0]  sample_type;
    logic [2:0]  channel_index;
    logic        frame_end;
  } pbq_entry_t;

endpackage

>>> rtl/core/pbq_if.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter channel interfaces
// Valid/ready byte channel and Q31 sample channel.
// ----------------------------------------------------------------------------
interface pbq_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pbq_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic [2:0]         channel_index;
  logic               frame_end;

  modport source (output valid, output sample_value, output channel_index,
                  output frame_end, input ready);
  modport sink   (input valid, input sample_value, input channel_index,
                  input frame_end, output ready);
endinterface

>>> rtl/core/pbq_cfg_regs.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter configuration registers
// APB-style register file holding sample format and channel count.
// ----------------------------------------------------------------------------
module pbq_cfg_regs import pbq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pbq_cfg_t          cfg
);

  pbq_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_TYPE:      cfg_r.sample_type      <= pwdata[1:0];
        REG_BYTES_PER_SAMPLE: cfg_r.bytes_per_sample <= pwdata[2:0];
        REG_LITTLE_ENDIAN:    cfg_r.little_endian    <= pwdata[0];
        REG_CHANNEL_COUNT:    cfg_r.channel_count    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SAMPLE_TYPE:      prdata = 32'(cfg_r.sample_type);
      REG_BYTES_PER_SAMPLE: prdata = 32'(cfg_r.bytes_per_sample);
      REG_LITTLE_ENDIAN:    prdata = 32'(cfg_r.little_endian);
      REG_CHANNEL_COUNT:    prdata = 32'(cfg_r.channel_count);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/pbq_front.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter front end
// Gathers bytes into samples, orders them and tracks the frame channel.
// ----------------------------------------------------------------------------
`include "pcm_bytes_to_q31_samples_unit_macros.svh"

module pbq_front import pbq_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pbq_cfg_t   cfg,
  pbq_byte_if.sink   in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output pbq_entry_t push_entry
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > 4) ? $clog2(MAX_CHANNELS + 1) : 4;

  logic [1:0]       byte_pos_r, byte_pos_nxt;
  logic [31:0]      asm_r;
  logic [POS_W-1:0] ch_pos_r, ch_pos_nxt;

  logic [2:0]       n_eff;
  logic [CNT_W-1:0] ch_cnt_ext, ch_eff, ch_pos_inc;
  logic [31:0]      word_cur;
  logic             complete, last, accept;

  function automatic logic [31:0] order_bytes(logic [31:0] w, logic [2:0] n, logic le);
    logic [31:0] r;
    logic [1:0]  slot;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      slot = le ? 2'(k) : 2'(n - 3'(k) - 3'd1);
      if (3'(k) < n) begin
        r[{slot, 3'b000} +: 8] = w[8*k +: 8];
      end
    end
    return r;
  endfunction

  always_comb begin
    if (cfg.bytes_per_sample < BYTES_MIN) begin
      n_eff = BYTES_MIN;
    end else if (cfg.bytes_per_sample > BYTES_MAX) begin
      n_eff = BYTES_MAX;
    end else begin
      n_eff = cfg.bytes_per_sample;
    end
  end

  assign ch_cnt_ext = CNT_W'(cfg.channel_count);
  assign ch_eff = (ch_cnt_ext == '0) ? CNT_W'(1) :
                  (ch_cnt_ext > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : ch_cnt_ext;
  assign ch_pos_inc = CNT_W'(ch_pos_r) + CNT_W'(1);
  assign last       = (ch_pos_inc >= ch_eff);

  assign complete = ({1'b0, byte_pos_r} + 3'd1) >= n_eff;
  // first byte of a sample starts from a clear word
  assign word_cur = ((byte_pos_r == 2'd0) ? 32'd0 : asm_r) |
                    (32'(in_ch.data_byte) << {byte_pos_r, 3'b000});

  // a byte that does not finish a sample needs no queue room
  assign in_ch.ready = push_ready || !complete;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = in_ch.valid && complete;

  assign push_entry.raw           = order_bytes(word_cur, n_eff, cfg.little_endian);
  assign push_entry.nbytes        = n_eff;
  assign push_entry.sample_type   = cfg.sample_type;
  assign push_entry.channel_index = 3'(ch_pos_r);
  assign push_entry.frame_end     = last;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    ch_pos_nxt   = ch_pos_r;
    if (accept) begin
      if (complete) begin
        byte_pos_nxt = 2'd0;
        ch_pos_nxt   = last ? '0 : POS_W'(ch_pos_inc);
      end else begin
        byte_pos_nxt = byte_pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= 2'd0;
      ch_pos_r   <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      ch_pos_r   <= ch_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      asm_r <= word_cur;
    end
  end

  `PBQ_ASSERT_NXT(a_front_pos_wrap, clk, rst_n, accept && complete, byte_pos_r == 2'd0)
  `PBQ_ASSERT_IMP(a_front_ch_bound, clk, rst_n, 1'b1, ch_pos_inc <= CNT_W'(MAX_CHANNELS))

endmodule

>>> rtl/core/pbq_queue.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter sample queue
// Short FIFO decoupling the byte front end from the decode back end.
// ----------------------------------------------------------------------------
`include "pcm_bytes_to_q31_samples_unit_macros.svh"

module pbq_queue import pbq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  pbq_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output pbq_entry_t pop_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pbq_entry_t       slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `PBQ_ASSERT_IMP(a_queue_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))

endmodule

>>> rtl/core/pbq_back.sv
// ----------------------------------------------------------------------------
// PCM to Q31 converter back end
// Decodes queued samples to Q1.31 and holds them in the output register.
// ----------------------------------------------------------------------------
`include "pcm_bytes_to_q31_samples_unit_macros.svh"

module pbq_back import pbq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  pbq_entry_t  pop_entry,
  pbq_sample_if.source out_ch
);

  logic        out_valid_r;
  logic [31:0] sample_r, sample_nxt;
  logic [2:0]  chidx_r;
  logic        fe_r;
  logic [31:0] just;
  logic [1:0]  pad_bytes;
  logic        pop;

  function automatic logic [31:0] float_to_q31(logic [31:0] bits);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [31:0] mag;
    logic [7:0]  lsh;
    logic [7:0]  rsh;
    logic [31:0] r;
    neg = bits[31];
    ex  = bits[30:23];
    man = {1'b1, bits[22:0]};
    lsh = ex - F_EXP_BASE;
    rsh = F_EXP_BASE - ex;
    mag = '0;
    if (ex == F_EXP_SPEC && bits[22:0] != '0) begin
      r = '0;                          // NaN
    end else if (ex == '0) begin
      r = '0;                          // zero and denormals
    end else if (ex >= F_EXP_SAT) begin
      r = neg ? Q31_NEG_FULL : Q31_POS_FULL;
    end else begin
      if (ex >= F_EXP_BASE) begin
        mag = 32'(man) << lsh[2:0];
      end else if (rsh >= F_MAN_BITS) begin
        mag = '0;
      end else begin
        mag = 32'(man) >> rsh[4:0];
      end
      r = neg ? (32'd0 - mag) : mag;
    end
    return r;
  endfunction

  assign pad_bytes = 2'(BYTES_MAX - pop_entry.nbytes);
  assign just      = pop_entry.raw << {pad_bytes, 3'b000};

  always_comb begin
    unique case (pop_entry.sample_type)
      SMP_SIGNED:   sample_nxt = just;
      SMP_UNSIGNED: sample_nxt = just ^ OFFSET_FLIP;
      SMP_FLOAT:    sample_nxt = (pop_entry.nbytes == BYTES_MAX) ?
                                 float_to_q31(pop_entry.raw) : 32'd0;
      default:      sample_nxt = 32'd0;
    endcase
  end

  // load whenever the output slot is empty or being drained
  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sample_r <= sample_nxt;
      chidx_r  <= pop_entry.channel_index;
      fe_r     <= pop_entry.frame_end;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_value  = $signed(sample_r);
  assign out_ch.channel_index = chidx_r;
  assign out_ch.frame_end     = fe_r;

  `PBQ_ASSERT_NXT(a_back_load_shows, clk, rst_n, pop, out_valid_r)

endmodule

>>> rtl/core/pcm_bytes_to_q31_samples_unit.sv
// ----------------------------------------------------------------------------
// PCM byte stream to Q1.31 sample converter
// Assembles 1..4 byte PCM samples and decodes them to signed Q1.31.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  in_ch   | sink      | data_byte[7:0]                           | valid/ready
//  out_ch  | source    | sample_value[31:0], channel_index, frame_end | valid/ready
//  cfg_*   | APB slave | 4 x 32-bit registers at 0x0, 0x4, 0x8, 0xC | psel/penable
//
//  One byte is accepted per clock unless the full queue holds off a completing byte;
//  a completing byte is written to the queue at its accepting edge, then loaded into
//  the single-entry output register, which is reloaded as it drains, to show on out_ch.
//  rst_n is synchronous; it clears config, byte and channel positions, queue and output.
//  A stalled out_ch fills the two-entry queue, after which bytes that would
//  complete a sample are held off; other bytes are still taken.
// ----------------------------------------------------------------------------
module pcm_bytes_to_q31_samples_unit import pbq_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  pbq_byte_if.sink          in_ch,
  pbq_sample_if.source      out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  pbq_cfg_t   cfg;
  logic       push_valid, push_ready;
  pbq_entry_t push_entry;
  logic       pop_valid, pop_ready;
  pbq_entry_t pop_entry;

  pbq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pbq_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  pbq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  pbq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule
